// ----- hw/rtl/pps_pkg.sv -----
`default_nettype none
package pps_pkg;
  localparam int SLOTS_DEFAULT = 64;
  localparam logic [6:0] PRIO_DEFAULT = 7'd60;
  localparam logic [6:0] PRIO_MAX = 7'd100;
  localparam logic [3:0] NICE_DEFAULT = 4'd5;
  localparam logic [31:0] U32_MAX = 32'hFFFF_FFFF;

  localparam logic [2:0] OP_ADMIT  = 3'd0;
  localparam logic [2:0] OP_UPDATE = 3'd1;
  localparam logic [2:0] OP_SETPRI = 3'd2;
  localparam logic [2:0] OP_TICK   = 3'd3;
  localparam logic [2:0] OP_PICK   = 3'd4;

  localparam logic [1:0] ST_NOT_READY = 2'd0;
  localparam logic [1:0] ST_RUNNABLE  = 2'd1;
  localparam logic [1:0] ST_RUNNING   = 2'd2;

  typedef struct packed {
    logic [2:0]  op;
    logic [5:0]  slot;
    logic [1:0]  run_state;
    logic [6:0]  priority_req;
    logic [31:0] sleep_amount;
    logic [31:0] now;
  } req_t;

  typedef struct packed {
    logic       found;
    logic [5:0] chosen_slot;
    logic [6:0] dyn_priority;
    logic [6:0] old_priority;
  } rsp_t;

  typedef struct packed {
    logic [1:0]  state;
    logic [6:0]  prio;
    logic [31:0] run;
    logic [31:0] sleep;
    logic [31:0] start_time;
    logic [31:0] picks;
  } ent_t;

  localparam ent_t ENT_RESET = '{state: ST_NOT_READY, prio: PRIO_DEFAULT, run: '0,
                                 sleep: '0, start_time: '0, picks: '0};
endpackage
`default_nettype wire

// ----- hw/rtl/pps_req_if.sv -----
`default_nettype none
interface pps_req_if;
  logic valid;
  logic ready;
  pps_pkg::req_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/pps_rsp_if.sv -----
`default_nettype none
interface pps_rsp_if;
  logic valid;
  logic ready;
  pps_pkg::rsp_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/pps_nice_div.sv -----
`default_nettype none
// niceness = sleep*10 / (run+sleep), one quotient bit a cycle (quotient <= 10)
module pps_nice_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] sleep,
  input  wire logic [31:0] run,
  output logic             done,
  output logic [3:0]       nice
);
  import pps_pkg::*;

  logic [35:0] rem;
  logic [35:0] dsh;
  logic [3:0]  q;
  logic [1:0]  step;
  logic        busy;
  logic        zr;
  logic [32:0] den;
  logic        ge;

  assign den  = {1'b0, run} + {1'b0, sleep};
  assign ge   = rem >= dsh;
  assign nice = zr ? NICE_DEFAULT : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (step == 2'd0);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == 2'd0) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= ({4'b0, sleep} << 3) + ({4'b0, sleep} << 1);
      dsh  <= {den, 3'b000};
      zr   <= (den == 33'd0);
      q    <= '0;
      step <= 2'd3;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      q    <= {q[2:0], ge};
      dsh  <= dsh >> 1;
      step <= step - 2'd1;
    end
  end

  property p_no_restart;
    @(posedge clk) disable iff (rst) !(start && busy);
  endproperty
  a_no_restart: assert property (p_no_restart) else $error("divider restarted while busy");

  property p_busy_after_start;
    @(posedge clk) disable iff (rst) start |=> busy;
  endproperty
  a_busy_after_start: assert property (p_busy_after_start)
    else $error("divider idle after start");

  property p_nice_range;
    @(posedge clk) disable iff (rst) done |-> nice <= 4'd10;
  endproperty
  a_nice_range: assert property (p_nice_range) else $error("niceness out of range");
endmodule
`default_nettype wire

// ----- hw/rtl/priority_process_selector.sv -----
// Admit writes its entry on acceptance; update and set priority read the entry and then
// write it back; tick sweeps every slot once; pick visits every slot, each runnable slot taking
// a memory read and a 4-step niceness divider, and then reads and updates the chosen slot.
// One word at a time; the next word is taken as soon as the slot table is idle.
// Reset: synchronous; the slot table is then cleared by a sweep over all SLOTS entries,
// one entry a cycle, during which no word is accepted.
`default_nettype none
module priority_process_selector #(
  parameter int SLOTS = pps_pkg::SLOTS_DEFAULT
) (
  input wire logic clk,
  input wire logic rst,
  pps_req_if.sink   req,
  pps_rsp_if.source rsp
);
  import pps_pkg::*;

  localparam int AW = $clog2(SLOTS);
  localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

  typedef enum logic [9:0] {
    S_CLR    = 10'b0000000001,
    S_IDLE   = 10'b0000000010,
    S_RMW    = 10'b0000000100,
    S_TICK   = 10'b0000001000,
    S_PEVAL  = 10'b0000010000,
    S_PDIV   = 10'b0000100000,
    S_PFIN   = 10'b0001000000,
    S_PUPD   = 10'b0010000000,
    S_DONE   = 10'b0100000000,
    S_SPARE  = 10'b1000000000
  } fsm_t;

  fsm_t          state;
  req_t          cur;
  rsp_t          res;
  logic [AW-1:0] idx;
  logic [AW-1:0] best;
  logic          have;
  logic [6:0]    best_dyn;
  logic [31:0]   best_picks;
  logic [31:0]   best_start;

  ent_t          mem [SLOTS];
  ent_t          mem_q;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  ent_t          mem_wdata;

  logic          div_start;
  logic          div_done;
  logic [3:0]    nice;
  logic [7:0]    dsum;
  logic [7:0]    ddiff;
  logic [6:0]    dyn;
  logic          better;
  logic          req_ok;
  logic [AW-1:0] req_addr;
  logic [6:0]    pr_sat;
  logic          acc;

  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_q <= mem[mem_raddr];
    end
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  pps_nice_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .sleep (mem_q.sleep),
    .run   (mem_q.run),
    .done  (div_done),
    .nice  (nice)
  );

  assign req.ready = (state == S_IDLE);
  assign acc       = req.valid && req.ready;
  assign req_ok    = 32'(req.data.slot) < 32'(SLOTS);
  assign req_addr  = AW'(req.data.slot);
  assign pr_sat    = (cur.priority_req > PRIO_MAX) ? PRIO_MAX : cur.priority_req;

  assign dsum  = {1'b0, mem_q.prio} + 8'd5;
  assign ddiff = dsum - {4'b0, nice};
  always_comb begin
    if (dsum < {4'b0, nice}) begin
      dyn = 7'd0;
    end else if (ddiff > {1'b0, PRIO_MAX}) begin
      dyn = PRIO_MAX;
    end else begin
      dyn = ddiff[6:0];
    end
  end

  assign better = !have || dyn < best_dyn ||
                  (dyn == best_dyn && (mem_q.picks < best_picks ||
                   (mem_q.picks == best_picks && mem_q.start_time < best_start)));

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = idx;
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = mem_q;
    div_start = 1'b0;
    case (state)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_wdata = ENT_RESET;
      end
      S_IDLE: begin
        if (acc) begin
          mem_raddr = req_addr;
          if (req.data.op == OP_ADMIT) begin
            mem_we          = req_ok;
            mem_waddr       = req_addr;
            mem_wdata       = ENT_RESET;
            mem_wdata.state = req.data.run_state;
          end else if (req.data.op == OP_UPDATE || req.data.op == OP_SETPRI) begin
            mem_re = req_ok;
          end else if (req.data.op == OP_TICK || req.data.op == OP_PICK) begin
            mem_re    = 1'b1;
            mem_raddr = '0;
          end
        end
      end
      S_RMW: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(cur.slot);
        if (cur.op == OP_UPDATE) begin
          mem_wdata.state = cur.run_state;
          mem_wdata.sleep = cur.sleep_amount;
        end else begin
          mem_wdata.prio = pr_sat;
        end
      end
      S_TICK: begin
        mem_we = (mem_q.state == ST_RUNNING) && (mem_q.run != U32_MAX);
        mem_wdata.run = mem_q.run + 32'd1;
        mem_re    = (idx != LAST);
        mem_raddr = idx + AW'(1);
      end
      S_PEVAL: begin
        div_start = (mem_q.state == ST_RUNNABLE);
        mem_re    = (mem_q.state != ST_RUNNABLE) && (idx != LAST);
        mem_raddr = idx + AW'(1);
      end
      S_PDIV: begin
        mem_re    = div_done && (idx != LAST);
        mem_raddr = idx + AW'(1);
      end
      S_PFIN: begin
        mem_re    = have;
        mem_raddr = best;
      end
      S_PUPD: begin
        mem_we               = 1'b1;
        mem_waddr            = best;
        mem_wdata.state      = ST_RUNNING;
        mem_wdata.start_time = cur.now;
        mem_wdata.picks      = (mem_q.picks == U32_MAX) ? U32_MAX : mem_q.picks + 32'd1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      idx       <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (state == S_DONE && (!rsp.valid || rsp.ready)) begin
        rsp.valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          idx <= idx + AW'(1);
          if (idx == LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (acc) begin
            idx <= '0;
            if ((req.data.op == OP_UPDATE || req.data.op == OP_SETPRI) && req_ok) begin
              state <= S_RMW;
            end else if (req.data.op == OP_TICK) begin
              state <= S_TICK;
            end else if (req.data.op == OP_PICK) begin
              state <= S_PEVAL;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_RMW: state <= S_DONE;
        S_TICK: begin
          idx <= idx + AW'(1);
          if (idx == LAST) begin
            state <= S_DONE;
          end
        end
        S_PEVAL: begin
          if (mem_q.state == ST_RUNNABLE) begin
            state <= S_PDIV;
          end else begin
            idx <= idx + AW'(1);
            if (idx == LAST) begin
              state <= S_PFIN;
            end
          end
        end
        S_PDIV: begin
          if (div_done) begin
            idx   <= idx + AW'(1);
            state <= (idx == LAST) ? S_PFIN : S_PEVAL;
          end
        end
        S_PFIN: state <= have ? S_PUPD : S_DONE;
        S_PUPD: state <= S_DONE;
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      cur  <= req.data;
      res  <= '0;
      have <= 1'b0;
    end
    if (state == S_RMW && cur.op == OP_SETPRI) begin
      res.old_priority <= mem_q.prio;
    end
    if (state == S_PDIV && div_done && better) begin
      have       <= 1'b1;
      best       <= idx;
      best_dyn   <= dyn;
      best_picks <= mem_q.picks;
      best_start <= mem_q.start_time;
    end
    if (state == S_PFIN && have) begin
      res.found        <= 1'b1;
      res.chosen_slot  <= 6'(best);
      res.dyn_priority <= best_dyn;
    end
    if (state == S_DONE && (!rsp.valid || rsp.ready)) begin
      rsp.data <= res;
    end
  end

  property p_no_rw_clash;
    @(posedge clk) disable iff (rst) !(mem_we && mem_re && mem_waddr == mem_raddr);
  endproperty
  a_no_rw_clash: assert property (p_no_rw_clash)
    else $error("read and write of one entry in the same cycle");

  property p_div_start;
    @(posedge clk) disable iff (rst) div_start |-> state == S_PEVAL;
  endproperty
  a_div_start: assert property (p_div_start)
    else $error("divider started outside slot evaluation");

  property p_pupd_have;
    @(posedge clk) disable iff (rst) state == S_PUPD |-> have;
  endproperty
  a_pupd_have: assert property (p_pupd_have) else $error("pick update with no chosen slot");

  property p_found_prio;
    @(posedge clk) disable iff (rst) rsp.valid && rsp.data.found |->
      rsp.data.dyn_priority <= PRIO_MAX;
  endproperty
  a_found_prio: assert property (p_found_prio) else $error("dynamic priority out of range");

  property p_clr_blocks;
    @(posedge clk) disable iff (rst) state == S_CLR |-> !req.ready;
  endproperty
  a_clr_blocks: assert property (p_clr_blocks) else $error("word taken during clear");
endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pps_pkg::*;

  localparam int NSLOT = 64;
  localparam int WATCHDOG = 20000;

  logic clk;
  logic rst;
  pps_req_if req ();
  pps_rsp_if rsp ();

  priority_process_selector #(.SLOTS(NSLOT)) dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // scheduler shadow
  logic [1:0]  sh_state [NSLOT];
  logic [6:0]  sh_prio  [NSLOT];
  logic [31:0] sh_run   [NSLOT];
  logic [31:0] sh_sleep [NSLOT];
  logic [31:0] sh_start [NSLOT];
  logic [31:0] sh_picks [NSLOT];

  rsp_t pending_rsp[$];
  int errors = 0;
  int watch = 0;
  bit quiet = 0;
  int idle_pct = 21;

  function automatic logic [6:0] dyn_prio(int i);
    logic [32:0] den;
    logic [35:0] nice;
    int d;
    den = {1'b0, sh_run[i]} + {1'b0, sh_sleep[i]};
    if (den == 0) nice = 5;
    else nice = ({4'd0, sh_sleep[i]} * 36'd10) / {3'd0, den};
    d = int'(sh_prio[i]) - int'(nice) + 5;
    if (d < 0) d = 0;
    if (d > 100) d = 100;
    return d[6:0];
  endfunction

  function automatic rsp_t schedule(req_t w);
    rsp_t r;
    bit have;
    int best;
    logic [6:0] bd, d;
    r = '0;
    case (w.op)
      OP_ADMIT: begin
        sh_state[w.slot] = w.run_state;
        sh_prio[w.slot] = PRIO_DEFAULT;
        sh_run[w.slot] = 0;
        sh_sleep[w.slot] = 0;
        sh_start[w.slot] = 0;
        sh_picks[w.slot] = 0;
      end
      OP_UPDATE: begin
        sh_state[w.slot] = w.run_state;
        sh_sleep[w.slot] = w.sleep_amount;
      end
      OP_SETPRI: begin
        r.old_priority = sh_prio[w.slot];
        sh_prio[w.slot] = (w.priority_req > PRIO_MAX) ? PRIO_MAX : w.priority_req;
      end
      OP_TICK: begin
        for (int i = 0; i < NSLOT; i++)
          if (sh_state[i] == ST_RUNNING && sh_run[i] != U32_MAX) sh_run[i]++;
      end
      OP_PICK: begin
        have = 0;
        best = 0;
        bd = 0;
        for (int i = 0; i < NSLOT; i++) begin
          if (sh_state[i] != ST_RUNNABLE) continue;
          d = dyn_prio(i);
          if (!have || d < bd || (d == bd && (sh_picks[i] < sh_picks[best] ||
              (sh_picks[i] == sh_picks[best] && sh_start[i] < sh_start[best])))) begin
            have = 1;
            best = i;
            bd = d;
          end
        end
        if (have) begin
          sh_state[best] = ST_RUNNING;
          sh_start[best] = w.now;
          if (sh_picks[best] != U32_MAX) sh_picks[best]++;
          r.found = 1'b1;
          r.chosen_slot = best[5:0];
          r.dyn_priority = bd;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // directed table; chk set where the result is obvious
  typedef struct {
    req_t w;
    bit chk;
    rsp_t r;
  } row_t;

  function automatic req_t mk(logic [2:0] op, logic [5:0] s, logic [1:0] st, logic [6:0] p,
                              logic [31:0] sl, logic [31:0] nw);
    req_t w;
    w.op = op; w.slot = s; w.run_state = st; w.priority_req = p;
    w.sleep_amount = sl; w.now = nw;
    return w;
  endfunction

  function automatic req_t rand_word();
    req_t w;
    int k;
    w.op = OP_PICK;
    k = $urandom_range(0, 99);
    if (k < 15) w.op = OP_ADMIT;
    else if (k < 35) w.op = OP_UPDATE;
    else if (k < 50) w.op = OP_SETPRI;
    else if (k < 65) w.op = OP_TICK;
    else if (k < 95) w.op = OP_PICK;
    else w.op = 3'($urandom_range(5, 7));
    w.slot = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7));
    w.run_state = 2'($urandom);
    if ($urandom_range(0, 3) != 0) w.run_state = $urandom_range(0, 1) ? ST_RUNNABLE : ST_RUNNING;
    w.priority_req = 7'($urandom);
    case ($urandom_range(0, 3))
      0: w.sleep_amount = $urandom;
      1: w.sleep_amount = U32_MAX - $urandom_range(0, 3);
      default: w.sleep_amount = $urandom_range(0, 20);
    endcase
    w.now = ($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 15);
    return w;
  endfunction

  bit drive_done = 0;

  task automatic send(req_t w, bit chk, rsp_t r);
    rsp_t e;
    while (!quiet && $urandom_range(0, 99) < idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid <= 1'b1;
    req.data <= w;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    e = schedule(w);
    if (chk && e != r) begin
      errors++;
      if (errors <= 10) $display("table row disagrees with shadow: %h vs %h", r, e);
    end
    pending_rsp.push_back(e);
    @(negedge clk);
  endtask

  initial begin
    row_t rows[$];
    rst = 1'b1;
    req.valid = 1'b0;
    req.data = '0;
    rsp.ready = 1'b0;
    for (int i = 0; i < NSLOT; i++) begin
      sh_state[i] = ST_NOT_READY; sh_prio[i] = PRIO_DEFAULT; sh_run[i] = 0;
      sh_sleep[i] = 0; sh_start[i] = 0; sh_picks[i] = 0;
    end
    rows.push_back('{mk(OP_PICK, 0, 0, 0, 0, 0), 1, '0});
    rows.push_back('{mk(OP_SETPRI, 63, 0, 127, 0, 0), 1, '{0, 0, 0, 60}});
    rows.push_back('{mk(OP_SETPRI, 63, 0, 0, 0, 0), 1, '{0, 0, 0, 100}});
    rows.push_back('{mk(OP_ADMIT, 63, ST_RUNNABLE, 0, 0, 0), 1, '0});
    rows.push_back('{mk(OP_PICK, 0, 0, 0, 0, 32'hFFFF_FFFF), 1, '{1, 63, 60, 0}});
    rows.push_back('{mk(OP_TICK, 0, 0, 0, 0, 0), 1, '0});
    rows.push_back('{mk(OP_ADMIT, 0, 3, 0, 0, 0), 1, '0});
    rows.push_back('{mk(OP_PICK, 0, 0, 0, 0, 0), 1, '0});
    rows.push_back('{mk(OP_UPDATE, 0, ST_RUNNABLE, 0, 32'hFFFF_FFFF, 0), 1, '0});
    rows.push_back('{mk(OP_SETPRI, 0, 0, 0, 0, 0), 1, '{0, 0, 0, 60}});
    rows.push_back('{mk(OP_PICK, 0, 0, 0, 0, 7), 1, '{1, 0, 0, 0}});
    rows.push_back('{mk(OP_ADMIT, 1, ST_RUNNABLE, 0, 0, 0), 0, '0});
    rows.push_back('{mk(OP_ADMIT, 2, ST_RUNNABLE, 0, 0, 0), 0, '0});
    rows.push_back('{mk(OP_PICK, 0, 0, 0, 0, 3), 0, '0});
    rows.push_back('{mk(OP_UPDATE, 1, ST_RUNNABLE, 0, 5, 0), 0, '0});
    rows.push_back('{mk(OP_PICK, 0, 0, 0, 0, 1), 0, '0});
    rows.push_back('{mk(OP_TICK, 0, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(3'd5, 9, 3, 127, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1, '0});
    rows.push_back('{mk(3'd7, 63, 3, 127, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1, '0});
    rows.push_back('{mk(OP_UPDATE, 2, ST_RUNNABLE, 0, 0, 0), 0, '0});
    rows.push_back('{mk(OP_PICK, 0, 0, 0, 0, 0), 0, '0});
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    foreach (rows[i]) send(rows[i].w, rows[i].chk, rows[i].r);
    for (int n = 0; n < 270; n++) begin
      if (n == 100) begin
        req.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(negedge clk);
        quiet = 1;
      end
      if (n == 160) quiet = 0;
      send(rand_word(), 0, '0);
    end
    req.valid <= 1'b0;
    drive_done = 1;
  end

  initial begin
    forever begin
      @(negedge clk);
      rsp.ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= idle_pct);
    end
  end

  always @(posedge clk) begin
    rsp_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_rsp.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %h", rsp.data);
      end else begin
        e = pending_rsp.pop_front();
        if (rsp.data.found !== e.found || rsp.data.chosen_slot !== e.chosen_slot ||
            rsp.data.dyn_priority !== e.dyn_priority ||
            rsp.data.old_priority !== e.old_priority) begin
          errors++;
          if (errors <= 10)
            $display("result mismatch: exp f%0d s%0d d%0d o%0d got f%0d s%0d d%0d o%0d",
                     e.found, e.chosen_slot, e.dyn_priority, e.old_priority,
                     rsp.data.found, rsp.data.chosen_slot, rsp.data.dyn_priority,
                     rsp.data.old_priority);
        end
      end
    end
  end

  initial begin
    int tail;
    tail = 0;
    forever begin
      @(posedge clk);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) watch = 0;
      else watch++;
      if (watch >= WATCHDOG) begin
        $display("CHECKS FAILED");
        $finish;
      end
      if (drive_done && pending_rsp.size() == 0) tail++;
      if (tail >= 8 * NSLOT) begin
        if (errors == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
      end
    end
  end
endmodule
`default_nettype wire
